### sv/wcj_pkg.sv
package wcj_pkg;

  // Default build sizes
  localparam int WCJ_MAX_JUMP    = 128;
  localparam int WCJ_HEIGHT_BITS = 16;
  localparam int WCJ_COST_BITS   = 32;

  // Jump limit register
  localparam int                       JUMP_LIMIT_BITS  = 8;
  localparam logic [JUMP_LIMIT_BITS-1:0] JUMP_LIMIT_RESET = 8'd1;

endpackage

### sv/wcj_ram.sv
module wcj_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/windowed_min_cost_jump_top.sv
// Least-cost path along a row of stones, one jump advancing 1..jump_limit
// stones at a cost of the absolute height difference.
//
// Input channel (in_valid / in_stall): one request per stone, carrying its
// height and a first flag that opens a new row (cost 0). The block stalls
// input while it works on a stone.
// Output channel (out_valid / out_stall): one request per stone with the
// least total cost and a flag when that cost sits at its maximum.
// Config channel (cfg_valid / cfg_ready): writes jump_limit; always ready,
// to be written only while the block is idle. Zero acts as 1, values above
// MAX_JUMP act as MAX_JUMP.
// Timing: a stone with n = min(jump_limit, stones already in its row)
// predecessors goes from accept through the scan state, which reads the
// n predecessors, to the write state that registers its result; a first
// stone skips the scan. The window RAM read port streams one predecessor
// per cycle into a single add/compare unit, which sets the rate.
// Reset (rst, synchronous): jump_limit returns to 1 and the row is empty;
// the window RAM is not cleared as no unwritten entry is ever read.
// If the output stays stalled, the finished result waits in the write step
// and no further stone is accepted until the held result has gone.
module windowed_min_cost_jump_top
  import wcj_pkg::*;
#(
  parameter int MAX_JUMP    = WCJ_MAX_JUMP,
  parameter int HEIGHT_BITS = WCJ_HEIGHT_BITS,
  parameter int COST_BITS   = WCJ_COST_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  // stone requests
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [HEIGHT_BITS-1:0]     height,
  input  logic                       first,
  // result requests
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COST_BITS-1:0]       cost,
  output logic                       saturated,
  // jump limit register
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [JUMP_LIMIT_BITS-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
  localparam int CNT_W  = $clog2(MAX_JUMP + 1);
  localparam int LIM_W  = (CNT_W > JUMP_LIMIT_BITS) ? CNT_W : JUMP_LIMIT_BITS;
  localparam int SUM_W  = ((COST_BITS > HEIGHT_BITS) ? COST_BITS : HEIGHT_BITS) + 1;
  localparam int WORD_W = HEIGHT_BITS + COST_BITS;

  localparam logic [COST_BITS-1:0] COST_MAX  = '1;
  localparam logic [ADDR_W-1:0]    LAST_SLOT = ADDR_W'(MAX_JUMP - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t                     state;
  logic [JUMP_LIMIT_BITS-1:0] jump_limit;
  logic [CNT_W-1:0]           stones_seen;
  logic [ADDR_W-1:0]          write_slot;
  logic [ADDR_W-1:0]          rd_addr;
  logic [CNT_W-1:0]           issue_cnt;
  logic                       rd_pend;
  logic [HEIGHT_BITS-1:0]     cur_height;
  logic                       cur_start;
  logic [COST_BITS-1:0]       best;

  logic                       in_accept;
  logic                       start;
  logic [LIM_W-1:0]           lim_ext;
  logic [CNT_W-1:0]           lim;
  logic [CNT_W-1:0]           n_pred;
  logic                       rd_en;
  logic                       wr_en;
  logic [WORD_W-1:0]          rd_data;
  logic [HEIGHT_BITS-1:0]     prev_height;
  logic [COST_BITS-1:0]       prev_cost;
  logic [HEIGHT_BITS-1:0]     diff;
  logic [SUM_W-1:0]           sum;
  logic [COST_BITS-1:0]       cand;
  logic [ADDR_W-1:0]          slot_before;

  function automatic logic [ADDR_W-1:0] dec_slot(input logic [ADDR_W-1:0] a);
    return (a == '0) ? LAST_SLOT : a - ADDR_W'(1);
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // effective limit and predecessor count
  always_comb begin
    lim_ext = LIM_W'(jump_limit);
    if (jump_limit == '0) begin
      lim_ext = LIM_W'(1);
    end else if (lim_ext > LIM_W'(MAX_JUMP)) begin
      lim_ext = LIM_W'(MAX_JUMP);
    end
    lim    = CNT_W'(lim_ext);
    start  = first || (stones_seen == '0);
    n_pred = (stones_seen < lim) ? stones_seen : lim;
  end

  assign slot_before = dec_slot(write_slot);
  assign rd_en       = (state == S_SCAN) && (issue_cnt != '0);
  assign wr_en       = (state == S_WRITE) && (!out_valid || !out_stall);

  wcj_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_JUMP)
  ) u_window (
    .clk   (clk),
    .we    (wr_en),
    .waddr (write_slot),
    .wdata ({cur_height, best}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // shared add/compare unit: candidate through one predecessor
  always_comb begin
    prev_height = rd_data[COST_BITS +: HEIGHT_BITS];
    prev_cost   = rd_data[COST_BITS-1:0];
    diff        = (cur_height >= prev_height) ? cur_height - prev_height
                                              : prev_height - cur_height;
    sum         = SUM_W'(prev_cost) + SUM_W'(diff);
    cand        = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      jump_limit  <= JUMP_LIMIT_RESET;
      stones_seen <= '0;
      write_slot  <= '0;
      issue_cnt   <= '0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        jump_limit <= cfg_data;
      end
      if (out_valid && !out_stall && !wr_en) begin
        out_valid <= 1'b0;
      end

      rd_pend <= rd_en;
      if (rd_pend && (cand < best)) begin
        best <= cand;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            cur_height <= height;
            cur_start  <= start;
            rd_addr    <= slot_before;
            if (start) begin
              best  <= '0;
              state <= S_WRITE;
            end else begin
              best      <= COST_MAX;
              issue_cnt <= n_pred;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            rd_addr   <= dec_slot(rd_addr);
            issue_cnt <= issue_cnt - CNT_W'(1);
          end
          // last compare lands on the same edge as the move
          if (issue_cnt == '0) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (wr_en) begin
            out_valid  <= 1'b1;
            cost       <= best;
            saturated  <= (best == COST_MAX);
            write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + ADDR_W'(1);
            if (cur_start) begin
              stones_seen <= CNT_W'(1);
            end else if (stones_seen < CNT_W'(MAX_JUMP)) begin
              stones_seen <= stones_seen + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### tb/windowed_min_cost_jump_top_test.sv
module windowed_min_cost_jump_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wcj_pkg::*;

  localparam int MJ = WCJ_MAX_JUMP;
  localparam int HB = WCJ_HEIGHT_BITS;
  localparam int CB = WCJ_COST_BITS;

  // One result request: least cost to a stone and its clip flag
  typedef struct packed {
    logic [CB-1:0] cost;
    logic          saturated;
  } cost_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [HB-1:0]              height = '0;
  logic                       first = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [CB-1:0]              cost;
  logic                       saturated;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [JUMP_LIMIT_BITS-1:0] cfg_data = '0;

  windowed_min_cost_jump_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .height    (height),
    .first     (first),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cost      (cost),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Idle rates in percent per cycle, changed by the tests between phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;

  // Set while in_valid is being held high by the stone sender, so that
  // it is lowered once only and never in the step that raises it again.
  bit holding_valid = 1'b0;

  // Costs still owed by the block, oldest first
  cost_result_t expected_costs[$];

  // Own copy of the row window: heights and least costs of the latest
  // stones of the current row, a circular write pointer and the row length
  // (saturating at the window depth).
  logic [HB-1:0]              slot_height [MJ];
  logic [CB-1:0]              slot_cost   [MJ];
  int unsigned                row_len   = 0;
  int unsigned                next_slot = 0;
  logic [JUMP_LIMIT_BITS-1:0] limit_now = JUMP_LIMIT_RESET;

  // Least cost of reaching this stone: min over the last n stones of the
  // row of their cost plus the height step, all sums clipped at the top.
  // A first flag, or no row open yet, starts a row at cost zero.
  function automatic cost_result_t predict_stone_cost(input logic [HB-1:0] h,
                                                      input logic f);
    int unsigned   lim;
    int unsigned   n;
    int unsigned   s;
    logic [HB-1:0] ph;
    logic [HB-1:0] diff;
    logic [CB:0]   sum;
    logic [CB-1:0] cand;
    logic [CB-1:0] best;
    cost_result_t  r;
    if (f || row_len == 0) begin
      row_len = 0;
      best = '0;
    end else begin
      // zero acts as one, anything past the window depth as the depth
      lim = (limit_now == 0) ? 1 : limit_now;
      if (lim > MJ) lim = MJ;
      n = (row_len < lim) ? row_len : lim;
      best = '1;
      for (int unsigned back = 1; back <= n; back++) begin
        s = (next_slot + MJ - back) % MJ;
        ph = slot_height[s];
        diff = (h >= ph) ? h - ph : ph - h;
        sum = slot_cost[s] + diff;
        cand = sum[CB] ? '1 : sum[CB-1:0];
        if (cand < best) best = cand;
      end
    end
    slot_height[next_slot] = h;
    slot_cost[next_slot] = best;
    next_slot = (next_slot + 1) % MJ;
    if (row_len < MJ) row_len++;
    r.cost = best;
    r.saturated = (best == '1);
    return r;
  endfunction

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  // Result checker: every accepted result request against the oldest cost owed
  always @(posedge clk) begin
    cost_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_costs.size() == 0) begin
        $error("result with none owed: cost %0d saturated %0b", cost, saturated);
        fail_count++;
      end else begin
        want = expected_costs.pop_front();
        if (cost !== want.cost) begin
          $error("cost: expected %0d, actual %0d", want.cost, cost);
          fail_count++;
        end
        if (saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, saturated);
          fail_count++;
        end
      end
    end
  end

  // One stone request. Idle cycles go ahead of it at the sender's rate;
  // valid stays high after the handshake in case another stone follows.
  task automatic send_stone(input logic [HB-1:0] h, input logic f);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      if (holding_valid) in_valid <= 1'b0;
      holding_valid = 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    height <= h;
    first <= f;
    holding_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_costs.push_back(predict_stone_cost(h, f));
  endtask

  // Stop sending and hold off until every owed cost has come back
  task automatic stop_and_drain();
    if (holding_valid) in_valid <= 1'b0;
    holding_valid = 1'b0;
    while (expected_costs.size() != 0) @(posedge clk);
  endtask

  // Register write; only called with the block idle
  task automatic write_jump_limit(input logic [JUMP_LIMIT_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = value;
  endtask

  // Straight after reset no row is open: a stone without the first flag
  // still starts one at cost zero. Reset limit of one applies after that.
  task automatic test_no_row_started();
    send_stone(16'd100, 1'b0);
    send_stone(16'd40, 1'b0);
    send_stone(16'hFFFF, 1'b0);
    stop_and_drain();
  endtask

  // Height extremes, both ways round, and a fresh row mid stream
  task automatic test_height_extremes();
    send_stone(16'h0000, 1'b1);
    send_stone(16'hFFFF, 1'b0);
    send_stone(16'h0000, 1'b0);
    send_stone(16'hFFFF, 1'b1);
    send_stone(16'h0000, 1'b0);
    stop_and_drain();
  endtask

  // A limit of zero behaves as one
  task automatic test_limit_zero();
    write_jump_limit('0);
    send_stone(16'd10, 1'b1);
    send_stone(16'd50, 1'b0);
    send_stone(16'd20, 1'b0);
    stop_and_drain();
  endtask

  // New limits take effect from the next stone of a row already under way,
  // over whatever of that row the window still holds.
  task automatic test_limit_change_mid_row();
    write_jump_limit(8'd3);
    send_stone(16'd0, 1'b1);
    send_stone(16'd1000, 1'b0);
    send_stone(16'd5, 1'b0);
    send_stone(16'd7, 1'b0);
    stop_and_drain();
    write_jump_limit(8'd1);
    send_stone(16'd900, 1'b0);
    stop_and_drain();
    write_jump_limit(8'd2);
    send_stone(16'd3, 1'b0);
    stop_and_drain();
  endtask

  // Limits past the window depth clip to the depth
  task automatic test_limit_too_large();
    write_jump_limit('1);
    send_stone(16'd300, 1'b1);
    send_stone(16'd10, 1'b0);
    send_stone(16'd400, 1'b0);
    stop_and_drain();
    write_jump_limit(8'(MJ));
    send_stone(16'd20, 1'b0);
    stop_and_drain();
  endtask

  // Limit one, heights swinging between the extremes back to back: each
  // step adds the full height range to the running cost.
  task automatic test_full_swing();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_jump_limit(8'd1);
    for (int k = 0; k < 16; k++)
      send_stone(k[0] ? 16'hFFFF : 16'h0000, k == 0);
    stop_and_drain();
  endtask

  // Random rows under random limits. Each segment drains, writes a limit,
  // then sends a few rows; now and then the first row carries on from the
  // row before, and a few stones get their first flag flipped.
  task automatic test_random_rows(input int send_pct, input int stall_pct,
                                  input int stones);
    int            sent;
    int            pick;
    int            lim;
    int            eff;
    int            rows;
    int            len;
    int            style;
    bit            keep_row;
    logic          f;
    logic [HB-1:0] h;
    logic [HB-1:0] base;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < stones) begin
      stop_and_drain();
      pick = $urandom_range(0, 99);
      if (pick < 55)      lim = $urandom_range(1, 8);
      else if (pick < 80) lim = $urandom_range(9, 40);
      else if (pick < 88) lim = $urandom_range(0, 1) ? 0 : 255;
      else if (pick < 95) lim = $urandom_range(41, 127);
      else                lim = $urandom_range(128, 255);
      write_jump_limit(JUMP_LIMIT_BITS'(lim));
      eff = (lim == 0) ? 1 : ((lim > MJ) ? MJ : lim);
      rows = (eff > 40) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      for (int r = 0; r < rows; r++) begin
        // long limits get rows past the window depth to wrap the window
        len = (eff > 40) ? $urandom_range(eff / 2, eff + 24)
                         : $urandom_range(1, 2 * eff + 4);
        keep_row = (r == 0) && ($urandom_range(0, 3) == 0);
        style = $urandom_range(0, 2);
        base = HB'($urandom);
        for (int k = 0; k < len; k++) begin
          f = (k == 0) && !keep_row;
          if ($urandom_range(0, 99) < 4) f = ~f;
          case (style)
            0: h = HB'($urandom_range(0, 65535));
            1: h = base + HB'($urandom_range(0, 255));
            default: h = $urandom_range(0, 1) ? '1 : '0;
          endcase
          send_stone(h, f);
          sent++;
        end
      end
    end
    stop_and_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_stall_pct = 59;
    test_no_row_started();
    test_height_extremes();
    test_limit_zero();
    test_limit_change_mid_row();
    test_limit_too_large();
    test_random_rows(30, 59, 500);
    test_random_rows(59, 30, 500);
    test_random_rows(0, 0, 450);
    test_full_swing();
    stop_and_drain();
    // watch for stray results after the drain
    repeat (2 * MJ) @(posedge clk);
    if (expected_costs.size() != 0) begin
      $error("%0d costs never came back", expected_costs.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("windowed_min_cost_jump_top test passed");
    else
      $display("windowed_min_cost_jump_top test failed");
    $finish;
  end

  // Watchdog, well past the slowest correct run
  initial begin
    #50_000_000;
    $display("windowed_min_cost_jump_top test failed");
    $finish;
  end

endmodule

### windowed_min_cost_jump_top.f
sv/wcj_pkg.sv
sv/wcj_ram.sv
sv/windowed_min_cost_jump_top.sv
tb/windowed_min_cost_jump_top_test.sv
